>>> rtl/core/spatiotemporal_denoise_lowpass_assert.svh
// Assertion macros for the spatiotemporal denoise lowpass block.
`ifndef SPATIOTEMPORAL_DENOISE_LOWPASS_ASSERT_SVH
`define SPATIOTEMPORAL_DENOISE_LOWPASS_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SDLP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdlp assertion failed");

`define SDLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdlp assertion failed");

`else

`define SDLP_ASSERT_SAME(label, ante, cons)

`define SDLP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/core/sdlp_pkg.sv
// Shared types, constants and filter-step functions of the denoise lowpass block.
`default_nettype none

package sdlp_pkg;

    localparam int PIX_W          = 8;
    localparam int COEF_W         = 9;
    localparam int COEF_IDX_W     = 9;
    localparam int TABLE_SEL_W    = 2;
    localparam int TABLE_DEPTH    = 1024;
    localparam int TABLE_ADDR_W   = 10;
    localparam int PLANE_WIDTH_W  = 12;
    localparam int PLANE_HEIGHT_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 2;

    localparam int DEFAULT_MAX_WIDTH  = 2048;
    localparam int DEFAULT_MAX_HEIGHT = 4096;

    localparam logic [PLANE_WIDTH_W-1:0]  RESET_PLANE_WIDTH  = 12'd2048;
    localparam logic [PLANE_HEIGHT_W-1:0] RESET_PLANE_HEIGHT = 13'd4096;

    localparam logic [COEF_IDX_W-1:0] DIFF_OFFSET = 9'd256;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_FILTER = 1'b1;

    localparam int TSEL_TEMPORAL_BIT = 0;
    localparam int TSEL_CHROMA_BIT   = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PLANE_WIDTH,
        CFG_PLANE_HEIGHT,
        CFG_CHROMA_PLANE
    } cfg_index_t;

    typedef struct packed {
        logic first_col;
        logic first_row;
        logic last_frame;
    } pos_flags_t;

    function automatic logic [COEF_IDX_W-1:0] lp_index(input logic [PIX_W-1:0] prev,
                                                        input logic [PIX_W-1:0] cur);
        logic [COEF_IDX_W-1:0] d;
        d = {1'b0, prev} + DIFF_OFFSET - {1'b0, cur};
        return d;
    endfunction

    function automatic logic [PIX_W-1:0] lp_sat(input logic [PIX_W-1:0] cur,
                                                input logic [COEF_W-1:0] c);
        logic [PIX_W+1:0] s;
        logic [PIX_W-1:0] r;
        s = {2'b00, cur} + {c[COEF_W-1], c};
        if (s[PIX_W+1])
        begin
            r = '0;
        end
        else if (s[PIX_W])
        begin
            r = '1;
        end
        else
        begin
            r = s[PIX_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/sdlp_in_if.sv
// Input channel: table loads and pixels with their previous-frame partners.
`default_nettype none

interface sdlp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 func;
    logic [sdlp_pkg::TABLE_SEL_W-1:0]     table_sel;
    logic [sdlp_pkg::COEF_IDX_W-1:0]      coef_index;
    logic signed [sdlp_pkg::COEF_W-1:0]   coef_value;
    logic [sdlp_pkg::PIX_W-1:0]           pixel;
    logic [sdlp_pkg::PIX_W-1:0]           prev_pixel;

    modport source (
        output valid, func, table_sel, coef_index, coef_value, pixel, prev_pixel,
        input  ready
    );

    modport sink (
        input  valid, func, table_sel, coef_index, coef_value, pixel, prev_pixel,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/sdlp_out_if.sv
// Output channel: filtered pixels with the end-of-frame mark.
`default_nettype none

interface sdlp_out_if;
    logic                       valid;
    logic                       ready;
    logic [sdlp_pkg::PIX_W-1:0] filtered_pixel;
    logic                       last_of_frame;

    modport source (
        output valid, filtered_pixel, last_of_frame,
        input  ready
    );

    modport sink (
        input  valid, filtered_pixel, last_of_frame,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/sdlp_ram.sv
// Generic single-write, single-read RAM with registered, enabled read data.
`default_nettype none

module sdlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/sdlp_pos.sv
// Raster position tracker with clamped plane size and column, row and frame flags.
`default_nettype none

module sdlp_pos #(
    parameter int MAX_WIDTH  = sdlp_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = sdlp_pkg::DEFAULT_MAX_HEIGHT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [sdlp_pkg::PLANE_WIDTH_W-1:0]  plane_width,
    input  wire logic [sdlp_pkg::PLANE_HEIGHT_W-1:0] plane_height,
    input  wire logic                                step,
    output logic      [$clog2(MAX_WIDTH)-1:0]        col,
    output sdlp_pkg::pos_flags_t                     flags
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > sdlp_pkg::PLANE_WIDTH_W) ?
                            $clog2(MAX_WIDTH + 1) : sdlp_pkg::PLANE_WIDTH_W;
    localparam int HCMP_W = ($clog2(MAX_HEIGHT + 1) > sdlp_pkg::PLANE_HEIGHT_W) ?
                            $clog2(MAX_HEIGHT + 1) : sdlp_pkg::PLANE_HEIGHT_W;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [WCMP_W-1:0] w_ext, w_eff, w_last, col_ext, col_eff;
    logic [HCMP_W-1:0] h_ext, h_eff, h_last, row_ext;
    logic              last_col, last_row;

    always_comb
    begin
        w_ext = WCMP_W'(plane_width);
        if (w_ext == '0)
        begin
            w_eff = WCMP_W'(1);
        end
        else if (w_ext > WCMP_W'(MAX_WIDTH))
        begin
            w_eff = WCMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_ext;
        end
        w_last  = w_eff - WCMP_W'(1);
        col_ext = WCMP_W'(col_reg);
        col_eff = (col_ext >= w_eff) ? w_last : col_ext;

        h_ext = HCMP_W'(plane_height);
        if (h_ext == '0)
        begin
            h_eff = HCMP_W'(1);
        end
        else if (h_ext > HCMP_W'(MAX_HEIGHT))
        begin
            h_eff = HCMP_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = h_ext;
        end
        h_last  = h_eff - HCMP_W'(1);
        row_ext = HCMP_W'(row_reg);

        last_col = (col_eff == w_last);
        last_row = (row_ext >= h_last);

        col              = col_eff[COL_W-1:0];
        flags.first_col  = (col_eff == '0);
        flags.first_row  = (row_reg == '0);
        flags.last_frame = last_col && last_row;

        col_next = col_reg;
        row_next = row_reg;
        if (step)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sdlp_pipe.sv
// Filter pipeline: table and line store RAMs, three lookup stages and the output register.
`default_nettype none

module sdlp_pipe #(
    parameter int MAX_WIDTH = sdlp_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                pix_accept,
    input  wire logic                                load_en,
    input  wire logic [sdlp_pkg::TABLE_SEL_W-1:0]    load_sel,
    input  wire logic [sdlp_pkg::COEF_IDX_W-1:0]     load_index,
    input  wire logic signed [sdlp_pkg::COEF_W-1:0]  load_value,
    input  wire logic [sdlp_pkg::PIX_W-1:0]          pixel,
    input  wire logic [sdlp_pkg::PIX_W-1:0]          prev_pixel,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]        col,
    input  wire sdlp_pkg::pos_flags_t                flags,
    input  wire logic                                chroma,
    input  wire logic                                out_ready,
    output logic                                     adv,
    output logic                                     busy,
    output logic                                     out_valid,
    output logic      [sdlp_pkg::PIX_W-1:0]          out_pixel,
    output logic                                     out_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int PW    = sdlp_pkg::PIX_W;
    localparam int CW    = sdlp_pkg::COEF_W;
    localparam int TAW   = sdlp_pkg::TABLE_ADDR_W;

    logic                 s1_valid_reg;
    logic [PW-1:0]        s1_pix_reg, s1_prv_reg;
    logic [COL_W-1:0]     s1_col_reg;
    sdlp_pkg::pos_flags_t s1_flags_reg;
    logic                 s1_bank_reg;

    logic                 s2_valid_reg;
    logic [PW-1:0]        s2_h_reg, s2_prv_reg;
    logic [COL_W-1:0]     s2_col_reg;
    logic                 s2_first_row_reg, s2_last_reg, s2_bank_reg;

    logic                 s3_valid_reg;
    logic [PW-1:0]        s3_v_reg;
    logic                 s3_last_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [PW-1:0]        out_pixel_reg;
    logic                 out_last_reg;

    logic [PW-1:0]        left_reg;
    logic                 lw_valid_reg;
    logic [COL_W-1:0]     lw_col_reg;
    logic [PW-1:0]        lw_data_reg;

    logic [CW-1:0]        hram_q, vram_q, tram_q;
    logic [PW-1:0]        line_q, line_fwd;
    logic [PW-1:0]        h1, left_now, v2, res3;
    logic [TAW-1:0]       load_addr, h_addr, v_addr, t_addr;
    logic                 load_spatial, load_temporal;

    assign adv  = !out_valid_reg || out_ready || !s3_valid_reg;
    assign busy = s1_valid_reg || s2_valid_reg || s3_valid_reg;

    always_comb
    begin
        load_addr     = {load_sel[sdlp_pkg::TSEL_CHROMA_BIT], load_index};
        load_spatial  = load_en && !load_sel[sdlp_pkg::TSEL_TEMPORAL_BIT];
        load_temporal = load_en && load_sel[sdlp_pkg::TSEL_TEMPORAL_BIT];

        h1       = s1_flags_reg.first_col ? s1_pix_reg : sdlp_pkg::lp_sat(s1_pix_reg, hram_q);
        left_now = s1_valid_reg ? h1 : left_reg;
        h_addr   = {chroma, sdlp_pkg::lp_index(left_now, pixel)};

        // The line entry may still be on its way into the line store.
        if (s2_valid_reg && (s2_col_reg == s1_col_reg))
        begin
            line_fwd = v2;
        end
        else if (lw_valid_reg && (lw_col_reg == s1_col_reg))
        begin
            line_fwd = lw_data_reg;
        end
        else
        begin
            line_fwd = line_q;
        end
        v_addr = {s1_bank_reg, sdlp_pkg::lp_index(line_fwd, h1)};

        v2     = s2_first_row_reg ? s2_h_reg : sdlp_pkg::lp_sat(s2_h_reg, vram_q);
        t_addr = {s2_bank_reg, sdlp_pkg::lp_index(s2_prv_reg, v2)};

        res3 = sdlp_pkg::lp_sat(s3_v_reg, tram_q);

        out_valid_next = out_valid_reg;
        if (adv)
        begin
            if (s3_valid_reg)
            begin
                out_valid_next = 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    sdlp_ram #(.WIDTH(CW), .DEPTH(sdlp_pkg::TABLE_DEPTH)) u_hram (
        .clk     (clk),
        .wr_en   (load_spatial),
        .wr_addr (load_addr),
        .wr_data ($unsigned(load_value)),
        .rd_en   (adv),
        .rd_addr (h_addr),
        .rd_data (hram_q)
    );

    sdlp_ram #(.WIDTH(CW), .DEPTH(sdlp_pkg::TABLE_DEPTH)) u_vram (
        .clk     (clk),
        .wr_en   (load_spatial),
        .wr_addr (load_addr),
        .wr_data ($unsigned(load_value)),
        .rd_en   (adv),
        .rd_addr (v_addr),
        .rd_data (vram_q)
    );

    sdlp_ram #(.WIDTH(CW), .DEPTH(sdlp_pkg::TABLE_DEPTH)) u_tram (
        .clk     (clk),
        .wr_en   (load_temporal),
        .wr_addr (load_addr),
        .wr_data ($unsigned(load_value)),
        .rd_en   (adv),
        .rd_addr (t_addr),
        .rd_data (tram_q)
    );

    sdlp_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line (
        .clk     (clk),
        .wr_en   (adv && s2_valid_reg),
        .wr_addr (s2_col_reg),
        .wr_data (v2),
        .rd_en   (adv),
        .rd_addr (col),
        .rd_data (line_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lw_valid_reg  <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                s1_valid_reg <= pix_accept;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                lw_valid_reg <= s2_valid_reg;
                if (s1_valid_reg)
                begin
                    left_reg <= h1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg       <= pixel;
            s1_prv_reg       <= prev_pixel;
            s1_col_reg       <= col;
            s1_flags_reg     <= flags;
            s1_bank_reg      <= chroma;

            s2_h_reg         <= h1;
            s2_prv_reg       <= s1_prv_reg;
            s2_col_reg       <= s1_col_reg;
            s2_first_row_reg <= s1_flags_reg.first_row;
            s2_last_reg      <= s1_flags_reg.last_frame;
            s2_bank_reg      <= s1_bank_reg;

            s3_v_reg         <= v2;
            s3_last_reg      <= s2_last_reg;

            lw_col_reg       <= s2_col_reg;
            lw_data_reg      <= v2;

            if (s3_valid_reg)
            begin
                out_pixel_reg <= res3;
                out_last_reg  <= s3_last_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/core/spatiotemporal_denoise_lowpass.sv
// Top level of the spatiotemporal denoise lowpass block.
`default_nettype none

// The block filters one pixel per clock while the output side does not stall: it can take a
// new pixel transfer while earlier pixels are still in flight, and a filtered pixel passes
// the three lookup stages and leaves through the output register. That rate is set by the
// horizontal recurrence, whose spatial table RAM read feeds the saturating add and the next
// address directly, and by giving each of the three lookups its own table RAM. Table load
// transfers also go at one per clock, but a load that follows pixels waits until those
// pixels have left the three lookup stages, and longer while a stalled result holds the
// last stage. Tables and the line store come up undefined; there is no clearing pass, so
// all tables in use must be loaded before the first pixel.

`include "spatiotemporal_denoise_lowpass_assert.svh"

module spatiotemporal_denoise_lowpass #(
    parameter int MAX_WIDTH  = sdlp_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = sdlp_pkg::DEFAULT_MAX_HEIGHT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    sdlp_in_if.sink                               pixels,
    sdlp_out_if.source                            results,
    input  wire logic                             cfg_write,
    input  wire logic [sdlp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sdlp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [sdlp_pkg::PLANE_WIDTH_W-1:0]  plane_width_reg;
    logic [sdlp_pkg::PLANE_HEIGHT_W-1:0] plane_height_reg;
    logic                                chroma_plane_reg;

    logic                 adv, busy, pix_accept, load_en;
    logic [COL_W-1:0]     col;
    sdlp_pkg::pos_flags_t flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_width_reg  <= sdlp_pkg::RESET_PLANE_WIDTH;
            plane_height_reg <= sdlp_pkg::RESET_PLANE_HEIGHT;
            chroma_plane_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (sdlp_pkg::cfg_index_t'(cfg_index))
                sdlp_pkg::CFG_PLANE_WIDTH:
                begin
                    plane_width_reg <= cfg_data[sdlp_pkg::PLANE_WIDTH_W-1:0];
                end
                sdlp_pkg::CFG_PLANE_HEIGHT:
                begin
                    plane_height_reg <= cfg_data;
                end
                sdlp_pkg::CFG_CHROMA_PLANE:
                begin
                    chroma_plane_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // A table load waits until no pixel in flight still has to read the tables.
    assign pixels.ready = (pixels.func == sdlp_pkg::FUNC_FILTER) ? adv : !busy;
    assign pix_accept   = pixels.valid && pixels.ready && (pixels.func == sdlp_pkg::FUNC_FILTER);
    assign load_en      = pixels.valid && pixels.ready && (pixels.func == sdlp_pkg::FUNC_LOAD);

    sdlp_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .clk          (clk),
        .rst_n        (rst_n),
        .plane_width  (plane_width_reg),
        .plane_height (plane_height_reg),
        .step         (pix_accept),
        .col          (col),
        .flags        (flags)
    );

    sdlp_pipe #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_accept (pix_accept),
        .load_en    (load_en),
        .load_sel   (pixels.table_sel),
        .load_index (pixels.coef_index),
        .load_value (pixels.coef_value),
        .pixel      (pixels.pixel),
        .prev_pixel (pixels.prev_pixel),
        .col        (col),
        .flags      (flags),
        .chroma     (chroma_plane_reg),
        .out_ready  (results.ready),
        .adv        (adv),
        .busy       (busy),
        .out_valid  (results.valid),
        .out_pixel  (results.filtered_pixel),
        .out_last   (results.last_of_frame)
    );

    `SDLP_ASSERT_SAME(a_load_only_when_drained, load_en, !busy)
    `SDLP_ASSERT_NEXT(a_load_leaves_pipe_empty, load_en, !busy)
    `SDLP_ASSERT_NEXT(a_frame_restarts, pix_accept && flags.last_frame, flags.first_col && flags.first_row)

endmodule

`default_nettype wire
